[design/sm4_cbc_encryptor_macros.svh]
// assertion macros for the sm4 cbc encryptor
`ifndef SM4_CBC_ENCRYPTOR_MACROS_SVH
`define SM4_CBC_ENCRYPTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SM4_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define SM4_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SM4_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define SM4_ASSERT_NR(lbl, clk_s, prop, msg)
`endif
`endif

[design/sm4_pkg.sv]
// shared constants, tables and types for the sm4 cbc encryptor
`default_nettype none
package sm4_pkg;

  localparam int CHAIN_COUNT_DEF = 16;
  localparam int CHAIN_ID_W      = 4;
  localparam int HALF_W          = 64;
  localparam int WORD_W          = 32;
  localparam int ROUNDS          = 32;
  localparam int RND_W           = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd3;

  localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
  localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
  localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
  localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX_ROM [0:255] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    logic              en;
    logic [RND_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } rk_wr_t;

  // schedule constant, byte j of word i is (4i+j)*7 mod 256
  function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] idx);
    logic [WORD_W-1:0] w;
    logic [7:0]        base;
    w = '0;
    base = {3'b000, idx} << 2;
    for (int j = 0; j < 4; j++) begin
      w = {w[WORD_W-9:0], 8'((base + 8'(j)) * 8'd7)};
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage
`default_nettype wire

[design/sm4_cbc_encryptor.sv]
// top level of the sm4 cbc encryptor with per-chain carry storage
//
// input channel: in_valid / in_stall carry one plaintext word (chain number,
// two 64-bit halves, last-block mark); a word is taken when in_valid is high
// and in_stall low. output channel: out_valid / out_stall return the
// ciphertext word with the chain number and last-block mark copied.
// config channel: cfg_valid / cfg_ready, cfg_index selects key high, key low,
// iv high, iv low; cfg_ready is always high.
// a word runs from acceptance to out_valid as follows: the carry memory is
// read at the accepting edge, then the chaining xor is loaded, 32 rounds run
// through the single shared round unit and the word commits; the next word is
// taken only after that commit, once the state is back in idle.
// a key write re-runs the key schedule on the same round unit, one setup
// step and 32 rounds; in_stall is high while the schedule is pending or running. after
// reset the schedule runs from the all-zero key, all chains start from the
// iv, and out_valid is low.
// when out_stall holds a finished word, the next word still enters and runs;
// it waits in the commit step until the output register frees up.
`default_nettype none
`include "sm4_cbc_encryptor_macros.svh"
module sm4_cbc_encryptor import sm4_pkg::*; #(
  parameter int CHAIN_COUNT = CHAIN_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CHAIN_ID_W-1:0] in_chain_id,
  input  wire logic [HALF_W-1:0]     in_plain_high,
  input  wire logic [HALF_W-1:0]     in_plain_low,
  input  wire logic                  in_final_block,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [CHAIN_ID_W-1:0] out_chain,
  output logic      [HALF_W-1:0]     out_cipher_high,
  output logic      [HALF_W-1:0]     out_cipher_low,
  output logic                       out_final,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [HALF_W-1:0]     cfg_data
);

  localparam int CHAIN_AW = (CHAIN_COUNT > 1) ? $clog2(CHAIN_COUNT) : 1;

  localparam logic [2:0] ST_KINIT = 3'd0;
  localparam logic [2:0] ST_KEXP  = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [RND_W-1:0]      cnt_r, cnt_nxt;
  logic                  kpend_r, kpend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]     x0_r, x1_r, x2_r, x3_r;
  logic [HALF_W-1:0]     key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [CHAIN_ID_W-1:0] chain_r;
  logic [CHAIN_AW-1:0]   idx_r;
  logic                  fin_r, track_r, open_hit_r;
  logic [HALF_W-1:0]     ph_r, pl_r;
  logic [2*HALF_W-1:0]   carry_mem [CHAIN_COUNT];
  logic [2*HALF_W-1:0]   carry_rd_r;
  logic [CHAIN_COUNT-1:0] open_r;
  logic [CHAIN_ID_W-1:0] out_chain_r;
  logic [HALF_W-1:0]     out_high_r, out_low_r;
  logic                  out_final_r;

  logic                  accept, cfg_we, out_load, carry_we, in_track;
  logic [CHAIN_AW-1:0]   in_idx;
  logic [2*HALF_W-1:0]   chain_src, mix;
  logic [WORD_W-1:0]     rk_in, rk_rd, y;
  rk_wr_t                rk_wr;

  assign in_stall  = (state_r != ST_IDLE) || kpend_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign carry_we  = out_load && track_r;
  assign in_track  = 32'(in_chain_id) < CHAIN_COUNT;
  assign in_idx    = CHAIN_AW'(in_chain_id);

  assign chain_src = open_hit_r ? carry_rd_r : {iv_high_r, iv_low_r};
  assign mix       = chain_src ^ {ph_r, pl_r};

  assign rk_in = (state_r == ST_KEXP) ? ck_word(cnt_r) : rk_rd;

  assign rk_wr.en   = (state_r == ST_KEXP);
  assign rk_wr.idx  = cnt_r;
  assign rk_wr.data = y;

  sm4_round u_round (
    .a0    (x0_r),
    .a1    (x1_r),
    .a2    (x2_r),
    .a3    (x3_r),
    .rk    (rk_in),
    .sched (state_r == ST_KEXP),
    .y     (y)
  );

  sm4_key_store u_keys (
    .clk     (clk),
    .wr      (rk_wr),
    .rd_idx  (cnt_r),
    .rd_data (rk_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kpend_nxt     = kpend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_KINIT: begin
        kpend_nxt = 1'b0;
        cnt_nxt   = '0;
        state_nxt = ST_KEXP;
      end
      ST_KEXP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (kpend_r) begin
          state_nxt = ST_KINIT;
        end else if (cnt_r == RND_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (kpend_r) begin
          state_nxt = ST_KINIT;
        end else if (accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_KINIT;
      end
    endcase
    if (cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)) begin
      kpend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KINIT;
      cnt_r       <= '0;
      kpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      open_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      kpend_r     <= kpend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_HIGH: key_high_r <= cfg_data;
          CFG_KEY_LOW:  key_low_r  <= cfg_data;
          CFG_IV_HIGH:  iv_high_r  <= cfg_data;
          CFG_IV_LOW:   iv_low_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (carry_we) begin
        open_r[idx_r] <= !fin_r;
      end
    end
  end

  // word registers and round datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      chain_r    <= in_chain_id;
      idx_r      <= in_idx;
      ph_r       <= in_plain_high;
      pl_r       <= in_plain_low;
      fin_r      <= in_final_block;
      track_r    <= in_track;
      open_hit_r <= in_track && open_r[in_idx];
    end
    case (state_r)
      ST_KINIT: begin
        x0_r <= key_high_r[63:32] ^ FK0;
        x1_r <= key_high_r[31:0] ^ FK1;
        x2_r <= key_low_r[63:32] ^ FK2;
        x3_r <= key_low_r[31:0] ^ FK3;
      end
      ST_LOAD: begin
        x0_r <= mix[127:96];
        x1_r <= mix[95:64];
        x2_r <= mix[63:32];
        x3_r <= mix[31:0];
      end
      ST_KEXP, ST_RUN: begin
        x0_r <= x1_r;
        x1_r <= x2_r;
        x2_r <= x3_r;
        x3_r <= y;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_chain_r <= chain_r;
      out_high_r  <= {x3_r, x2_r};
      out_low_r   <= {x1_r, x0_r};
      out_final_r <= fin_r;
    end
  end

  // carry memory
  always_ff @(posedge clk) begin
    if (carry_we) begin
      carry_mem[idx_r] <= {x3_r, x2_r, x1_r, x0_r};
    end
    if (accept) begin
      carry_rd_r <= carry_mem[in_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chain       = out_chain_r;
  assign out_cipher_high = out_high_r;
  assign out_cipher_low  = out_low_r;
  assign out_final       = out_final_r;

  `SM4_ASSERT_NR(a_reset_state, clk, !rst_n |=> (state_r == ST_KINIT && !out_valid_r), "reset did not restart key schedule")
  `SM4_ASSERT(a_accept_load, clk, rst_n, accept |=> (state_r == ST_LOAD), "accepted word did not enter load")
  `SM4_ASSERT(a_last_round, clk, rst_n, (state_r == ST_RUN && cnt_r == RND_LAST) |=> (state_r == ST_FIN), "round count overrun")
  `SM4_ASSERT(a_out_load, clk, rst_n, out_load |=> (out_valid_r && state_r != ST_FIN), "committed word not presented")
  `SM4_ASSERT(a_kpend_stall, clk, rst_n, kpend_r |-> in_stall, "word taken with key schedule pending")

endmodule
`default_nettype wire

[design/sm4_round.sv]
// shared sm4 round unit, cipher or key schedule linear transform
`default_nettype none
module sm4_round import sm4_pkg::*; (
  input  wire logic [WORD_W-1:0] a0,
  input  wire logic [WORD_W-1:0] a1,
  input  wire logic [WORD_W-1:0] a2,
  input  wire logic [WORD_W-1:0] a3,
  input  wire logic [WORD_W-1:0] rk,
  input  wire logic              sched,
  output logic      [WORD_W-1:0] y
);

  logic [WORD_W-1:0] s;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] l;

  always_comb begin
    s = a1 ^ a2 ^ a3 ^ rk;
    b = {SBOX_ROM[s[31:24]], SBOX_ROM[s[23:16]], SBOX_ROM[s[15:8]], SBOX_ROM[s[7:0]]};
    if (sched) begin
      l = b ^ rotl32(b, 13) ^ rotl32(b, 23);
    end else begin
      l = b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    end
    y = a0 ^ l;
  end

endmodule
`default_nettype wire

[design/sm4_key_store.sv]
// round key register file, one write and one read port
`default_nettype none
module sm4_key_store import sm4_pkg::*; (
  input  wire logic              clk,
  input  wire rk_wr_t            wr,
  input  wire logic [RND_W-1:0]  rd_idx,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] rk_r [ROUNDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rk_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = rk_r[rd_idx];

endmodule
`default_nettype wire

[tb/tb_sm4_cbc_encryptor.sv]
// testbench for the sm4 cbc encryptor: chained blocks checked against a behavioral cipher model
`timescale 1ns / 1ps
module tb_sm4_cbc_encryptor;
  import sm4_pkg::*;

  localparam int NUM_CHAINS  = CHAIN_COUNT_DEF;
  localparam int CFG_SETTLE  = 40;
  localparam int DRAIN_TAIL  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAIN_ID_W-1:0] chain;
    logic [HALF_W-1:0]     hi;
    logic [HALF_W-1:0]     lo;
    logic                  fin;
  } cipher_word_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [CHAIN_ID_W-1:0] in_chain_id    = '0;
  logic [HALF_W-1:0]     in_plain_high  = '0;
  logic [HALF_W-1:0]     in_plain_low   = '0;
  logic                  in_final_block = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CHAIN_ID_W-1:0] out_chain;
  logic [HALF_W-1:0]     out_cipher_high;
  logic [HALF_W-1:0]     out_cipher_low;
  logic                  out_final;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [HALF_W-1:0]     cfg_data       = '0;

  // cipher model state
  logic [HALF_W-1:0] key_hi, key_lo, iv_hi, iv_lo;
  logic [WORD_W-1:0] round_key [ROUNDS];
  logic [HALF_W-1:0] chain_carry_hi [NUM_CHAINS];
  logic [HALF_W-1:0] chain_carry_lo [NUM_CHAINS];
  logic              chain_live [NUM_CHAINS];
  cipher_word_t      expected_ciphers [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stuck_cycles   = 0;
  int mismatch_count = 0;

  sm4_cbc_encryptor i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_chain_id     (in_chain_id),
    .in_plain_high   (in_plain_high),
    .in_plain_low    (in_plain_low),
    .in_final_block  (in_final_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chain       (out_chain),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .out_final       (out_final),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] w, input int n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {w, w} << n;
    return dbl[2*WORD_W-1 -: WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = SBOX_ROM[w[8*b +: 8]];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] data_mix(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] b;
    b = sbox_word(w);
    return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  function automatic logic [WORD_W-1:0] key_mix(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] b;
    b = sbox_word(w);
    return b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  function automatic void expand_round_keys();
    logic [WORD_W-1:0] k [4];
    logic [WORD_W-1:0] ck, nk;
    k[0] = key_hi[63:32] ^ FK0;
    k[1] = key_hi[31:0] ^ FK1;
    k[2] = key_lo[63:32] ^ FK2;
    k[3] = key_lo[31:0] ^ FK3;
    for (int i = 0; i < ROUNDS; i++) begin
      for (int j = 0; j < 4; j++) ck[8*(3-j) +: 8] = 8'((4*i + j) * 7);
      nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck);
      round_key[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
  endfunction

  function automatic logic [2*HALF_W-1:0] sm4_encrypt(input logic [2*HALF_W-1:0] blk);
    logic [WORD_W-1:0] x [4];
    logic [WORD_W-1:0] nx;
    x[0] = blk[127:96];
    x[1] = blk[95:64];
    x[2] = blk[63:32];
    x[3] = blk[31:0];
    for (int i = 0; i < ROUNDS; i++) begin
      nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ round_key[i]);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  function automatic cipher_word_t chain_encrypt(input logic [CHAIN_ID_W-1:0] chain,
                                                 input logic [HALF_W-1:0] ph,
                                                 input logic [HALF_W-1:0] pl,
                                                 input logic fin);
    cipher_word_t r;
    logic [2*HALF_W-1:0] x, c;
    logic tracked;
    tracked = int'(chain) < NUM_CHAINS;
    x = {iv_hi, iv_lo};
    if (tracked && chain_live[chain]) x = {chain_carry_hi[chain], chain_carry_lo[chain]};
    c = sm4_encrypt(x ^ {ph, pl});
    if (tracked) begin
      chain_carry_hi[chain] = c[127:64];
      chain_carry_lo[chain] = c[63:0];
      chain_live[chain] = !fin;
    end
    r.chain = chain;
    r.hi = c[127:64];
    r.lo = c[63:0];
    r.fin = fin;
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input logic [CHAIN_ID_W-1:0] chain, input logic [HALF_W-1:0] ph,
                            input logic [HALF_W-1:0] pl, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_chain_id    <= chain;
    in_plain_high  <= ph;
    in_plain_low   <= pl;
    in_final_block <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_ciphers.push_back(chain_encrypt(chain, ph, pl, fin));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ciphers.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_KEY_HIGH: begin
        key_hi = val;
        expand_round_keys();
      end
      CFG_KEY_LOW: begin
        key_lo = val;
        expand_round_keys();
      end
      CFG_IV_HIGH: iv_hi = val;
      CFG_IV_LOW:  iv_lo = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    // key writes rerun the schedule on the round unit
    repeat (CFG_SETTLE) @(negedge clk);
  endtask

  task automatic test_directed();
    send_block(4'd0, '0, '0, 1'b0);
    send_block(4'd0, '1, '1, 1'b1);
    send_block(4'd15, '1, '0, 1'b1);
    send_block(4'd0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
    wait_all_results();
    write_reg(CFG_KEY_HIGH, 64'h0123456789abcdef);
    write_reg(CFG_KEY_LOW, 64'hfedcba9876543210);
    send_block(4'd1, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    send_block(4'd2, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    send_block(4'd3, '0, '1, 1'b0);
    send_block(4'd2, '1, '1, 1'b0);
    wait_all_results();
    // iv change with chains open
    write_reg(CFG_IV_HIGH, '1);
    write_reg(CFG_IV_LOW, '1);
    send_block(4'd2, '0, '0, 1'b0);
    send_block(4'd4, '0, '0, 1'b0);
    wait_all_results();
    // key change with chains open
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    send_block(4'd2, 64'h8000000000000001, 64'h0000000180000000, 1'b1);
    send_block(4'd3, '1, '0, 1'b1);
    send_block(4'd4, '0, '1, 1'b0);
    send_block(4'd4, '1, '1, 1'b1);
    send_block(4'd15, '0, '0, 1'b0);
    send_block(4'd15, '0, '0, 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_chains(input int count, input int s_pct, input int r_pct);
    wait_all_results();
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    write_reg(CFG_KEY_HIGH, rand_half());
    write_reg(CFG_KEY_LOW, rand_half());
    write_reg(CFG_IV_HIGH, rand_half());
    write_reg(CFG_IV_LOW, rand_half());
    for (int n = 0; n < count; n++) begin
      send_block(CHAIN_ID_W'($urandom_range(NUM_CHAINS - 1)), rand_half(), rand_half(),
                 $urandom_range(4) == 0);
    end
    wait_all_results();
  endtask

  task automatic test_backpressure();
    wait_all_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req++;
    for (int n = 0; n < 12; n++) begin
      send_block(CHAIN_ID_W'($urandom_range(3)), rand_half(), rand_half(),
                 $urandom_range(3) == 0);
    end
    wait_all_results();
    for (int n = 0; n < 8; n++) begin
      send_block(CHAIN_ID_W'($urandom_range(NUM_CHAINS - 1)), rand_half(), rand_half(),
                 1'($urandom_range(1)));
    end
    wait_all_results();
  endtask

  task automatic report_mismatch(input string what, input logic have_want,
                                 input cipher_word_t want, input cipher_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (have_want)
        $display("%0t %s: exp chain %0d %h %h final %0b, got chain %0d %h %h final %0b",
                 $realtime, what, want.chain, want.hi, want.lo, want.fin,
                 got.chain, got.hi, got.lo, got.fin);
      else
        $display("%0t %s: got chain %0d %h %h final %0b",
                 $realtime, what, got.chain, got.hi, got.lo, got.fin);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    cipher_word_t want, got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_chain, out_cipher_high, out_cipher_low, out_final};
      if (expected_ciphers.size() == 0) begin
        report_mismatch("unexpected word", 1'b0, got, got);
      end else begin
        want = expected_ciphers.pop_front();
        if (got.chain !== want.chain || got.hi !== want.hi ||
            got.lo !== want.lo || got.fin !== want.fin)
          report_mismatch("word mismatch", 1'b1, want, got);
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb_sm4_cbc_encryptor failed");
    $finish;
  end

  initial begin
    key_hi = '0;
    key_lo = '0;
    iv_hi  = '0;
    iv_lo  = '0;
    for (int c = 0; c < NUM_CHAINS; c++) begin
      chain_carry_hi[c] = '0;
      chain_carry_lo[c] = '0;
      chain_live[c] = 1'b0;
    end
    expand_round_keys();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 38;
    recv_stall_pct = 59;
    test_directed();
    test_random_chains(650, 38, 59);
    test_random_chains(650, 59, 38);
    test_random_chains(630, 0, 0);
    test_backpressure();
    if (mismatch_count == 0 && expected_ciphers.size() == 0)
      $display("tb_sm4_cbc_encryptor passed");
    else
      $display("tb_sm4_cbc_encryptor failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/sm4_pkg.sv
design/sm4_round.sv
design/sm4_key_store.sv
design/sm4_cbc_encryptor.sv
tb/tb_sm4_cbc_encryptor.sv
